>>> src/double_ended_queue_top_macros.svh
// Assertion helpers used by dq_ctrl.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dq_pkg.sv
package dq_pkg;

  localparam int FILL_W = 5;

  localparam logic [1:0] CMD_PUSH_TAIL = 2'd0;
  localparam logic [1:0] CMD_PUSH_HEAD = 2'd1;
  localparam logic [1:0] CMD_POP_HEAD  = 2'd2;
  localparam logic [1:0] CMD_POP_TAIL  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0] code;
    logic [31:0] price;
  } record_t;

endpackage

>>> src/double_ended_queue_top.sv
// Double-ended queue of 64-bit records in a ring-addressed synchronous RAM.
// A push or a failed request yields its result in the cycle after acceptance; a successful
// pop first loads the RAM read register and enters S_READ, then registers its result.
// Throughput: one push per cycle unless the output stalls; a pop holds off requests in S_READ.
// Reset clears the front index, the entry count and the result valid; the RAM is not cleared.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic signed [31:0]        in_item_code,
  input  logic [31:0]               in_price_bits,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic signed [31:0]        out_code,
  output logic [31:0]               out_price,
  output logic [dq_pkg::FILL_W-1:0] out_fill_level
);
  import dq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  record_t       mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  record_t       mem_rdata;

  dq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_item_code   (in_item_code),
    .in_price_bits  (in_price_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_code       (out_code),
    .out_price      (out_price),
    .out_fill_level (out_fill_level),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  dq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> src/dq_ram.sv
module dq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  dq_pkg::record_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output dq_pkg::record_t rdata
);
  import dq_pkg::*;

  record_t mem [DEPTH];
  record_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/dq_ctrl.sv
`include "double_ended_queue_top_macros.svh"

module dq_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic signed [31:0]          in_item_code,
  input  logic [31:0]                 in_price_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_code,
  output logic [31:0]                 out_price,
  output logic [dq_pkg::FILL_W-1:0]   out_fill_level,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output dq_pkg::record_t             mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  dq_pkg::record_t             mem_rdata
);
  import dq_pkg::*;

  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic              state_r, state_nxt;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [31:0]       out_code_r, out_code_nxt;
  logic [31:0]       out_price_r, out_price_nxt;
  logic [FILL_W-1:0] out_fill_r, out_fill_nxt;

  logic              in_acc;
  logic              full;
  logic              empty;
  logic [SW-1:0]     sum_tail;
  logic [SW-1:0]     sum_last;
  logic [AW-1:0]     tail_slot;
  logic [AW-1:0]     last_slot;
  logic [AW-1:0]     prev_front;
  logic [AW-1:0]     next_front;

  assign in_stall = (state_r == S_READ) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);

  assign sum_tail  = SW'(front_r) + SW'(count_r);
  assign sum_last  = sum_tail - SW'(1);
  assign tail_slot = AW'((sum_tail >= DEPTH_S) ? sum_tail - DEPTH_S : sum_tail);
  assign last_slot = AW'((sum_last >= DEPTH_S) ? sum_last - DEPTH_S : sum_last);
  assign prev_front = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign next_front = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);

  assign mem_wdata.code  = in_item_code;
  assign mem_wdata.price = in_price_bits;

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    mem_we         = 1'b0;
    mem_waddr      = tail_slot;
    mem_re         = 1'b0;
    mem_raddr      = front_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_code_nxt   = out_code_r;
    out_price_nxt  = out_price_r;
    out_fill_nxt   = out_fill_r;

    if (state_r == S_READ) begin
      // read data for the pending pop arrives now
      state_nxt      = S_IDLE;
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_code_nxt   = mem_rdata.code;
      out_price_nxt  = mem_rdata.price;
      out_fill_nxt   = FILL_W'(count_r);
    end else if (in_acc) begin
      out_status_nxt = ST_OK;
      out_code_nxt   = '0;
      out_price_nxt  = '0;
      unique case (in_cmd)
        CMD_PUSH_TAIL: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = tail_slot;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_PUSH_HEAD: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = prev_front;
            front_nxt = prev_front;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP_HEAD: begin
          if (empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = front_r;
            front_nxt = next_front;
            count_nxt = count_r - CW'(1);
            state_nxt = S_READ;
          end
        end
        CMD_POP_TAIL: begin
          if (empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = last_slot;
            count_nxt = count_r - CW'(1);
            state_nxt = S_READ;
          end
        end
      endcase
      // pops finish when the read data returns
      out_valid_nxt = (state_nxt == S_IDLE);
      out_fill_nxt  = FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_code_r   <= out_code_nxt;
    out_price_r  <= out_price_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_code       = out_code_r;
  assign out_price      = out_price_r;
  assign out_fill_level = out_fill_r;

  `DQ_ASSERT_NOW(a_count_range, 1'b1, count_r <= FULL_CNT, "entry count exceeds depth")
  `DQ_ASSERT_NOW(a_front_range, 1'b1, front_r <= LAST_IDX, "front index out of range")
  `DQ_ASSERT_NOW(a_read_slot_free, state_r == S_READ, !out_valid_r, "pop result has no free slot")
  `DQ_ASSERT_NEXT(a_push_count, in_acc && !in_cmd[1] && !full, count_r == $past(count_r) + CW'(1), "push did not advance count")
  `DQ_ASSERT_NEXT(a_pop_result, in_acc && in_cmd[1] && !empty, state_r == S_READ && !out_valid_r, "pop did not wait for read data")

endmodule
